// ===== rtl/core/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// crt_pkg: shared types and constants
// Widths, divider request/response structs and sequencer states.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int MOD_W  = 31;              // coordinate / modulus width
    localparam int WIDE_W = 2 * MOD_W;       // product / wide dividend width
    localparam int IDX_W  = 16;              // best_index width
    localparam int SGN_W  = MOD_W + 2;       // Bezout coefficient width
    localparam int PRD_W  = 64;              // multiplier result width
    localparam int CNT_W  = $clog2(WIDE_W + 1);
    localparam int MAX_POINTS_DEF = 65536;

    localparam logic [1:0] CFG_MOD_X  = 2'd0;
    localparam logic [1:0] CFG_MOD_Y  = 2'd1;
    localparam logic [1:0] CFG_STEP_X = 2'd2;
    localparam logic [1:0] CFG_STEP_Y = 2'd3;

    typedef struct packed {
        logic              start;
        logic              wide;      // 1: 62-bit dividend, 0: 31-bit dividend
        logic [WIDE_W-1:0] dividend;
        logic [MOD_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] quot;
        logic [MOD_W-1:0]  rem;
    } t_div_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DX1, ST_DX2, ST_DY1, ST_DY2,
        ST_EG_DIV, ST_EG_MUL, ST_EG_UPD,
        ST_SV_CHK, ST_SV_P, ST_SV_NX, ST_SV_MUL, ST_SV_RED,
        ST_CR_A1, ST_CR_A2, ST_CR_M2G, ST_CR_CM, ST_CR_DQ, ST_CR_DQM,
        ST_CR_XM, ST_CR_MK, ST_CR_K, ST_CR_MT, ST_CR_T,
        ST_FIN, ST_EMIT
    } t_state;

endpackage

// ===== rtl/core/crt_pt_if.sv =====
// ----------------------------------------------------------------------------
// crt_pt_if: point input channel
// valid/ready channel carrying one point of a run.
// ----------------------------------------------------------------------------
interface crt_pt_if;
    import crt_pkg::*;

    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] pos_x;
    logic [MOD_W-1:0] pos_y;
    logic             last;

    modport source (output valid, output pos_x, output pos_y, output last, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input last, output ready);
endinterface

// ===== rtl/core/crt_res_if.sv =====
// ----------------------------------------------------------------------------
// crt_res_if: result output channel
// valid/ready channel carrying the earliest-hit result of a run.
// ----------------------------------------------------------------------------
interface crt_res_if;
    import crt_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [IDX_W-1:0]  best_index;
    logic [WIDE_W-1:0] best_time;

    modport source (output valid, output found, output best_index, output best_time,
                    input ready);
    modport sink   (input valid, input found, input best_index, input best_time,
                    output ready);
endinterface

// ===== rtl/core/crt_div.sv =====
// ----------------------------------------------------------------------------
// crt_div: shared iterative divider
// Restoring radix-2 unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crt_pkg::t_div_req i_req,
    output crt_pkg::t_div_rsp o_rsp
);
    import crt_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WIDE_W-1:0] r_q;
    logic [MOD_W-1:0]  r_rem;
    logic [MOD_W-1:0]  r_dvs;

    logic [MOD_W:0]    n_shift;
    logic              n_bit;
    logic [MOD_W-1:0]  n_rem;

    always_comb begin
        n_shift = {r_rem, r_q[WIDE_W-1]};
        n_bit   = (n_shift >= {1'b0, r_dvs});
        n_rem   = n_bit ? MOD_W'(n_shift - {1'b0, r_dvs}) : n_shift[MOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.wide ? CNT_W'(WIDE_W) : CNT_W'(MOD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.wide ? i_req.dividend
                                : {i_req.dividend[MOD_W-1:0], {(WIDE_W-MOD_W){1'b0}}};
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[WIDE_W-2:0], n_bit};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;
endmodule

// ===== rtl/core/crt_mul.sv =====
// ----------------------------------------------------------------------------
// crt_mul: shared registered multiplier
// Signed coefficient times unsigned operand, product held until next enable.
// ----------------------------------------------------------------------------
module crt_mul (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [crt_pkg::SGN_W-1:0]  i_a,
    input  logic        [crt_pkg::MOD_W-1:0]  i_b,
    output logic signed [crt_pkg::PRD_W-1:0]  o_p
);
    import crt_pkg::*;

    logic signed [SGN_W+MOD_W:0] n_full;
    logic signed [PRD_W-1:0]     r_p;

    assign n_full = i_a * $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_full[PRD_W-1:0];
        end
    end

    assign o_p = r_p;
endmodule

// ===== rtl/core/congruence_crt_earliest_hit.sv =====
// ----------------------------------------------------------------------------
// congruence_crt_earliest_hit: earliest common hit over a run of points
// Solves two linear congruences per point by extended Euclid, merges by CRT.
// ----------------------------------------------------------------------------
// The first point of a run is the reference. For every point the block solves
// t*step_x = dx (mod mod_x) and t*step_y = dy (mod mod_y), merges the two
// classes by CRT and keeps the earliest positive time (lowest index on ties).
// The point flagged last produces one result transfer. All divides and
// multiplies run on one shared restoring divider (one quotient bit per cycle,
// 31-bit or 62-bit dividend) and one registered multiplier, under a
// sequencer. A point costs 16 narrow and 3 wide divides plus one narrow
// divide and one multiply per Euclid step over the three Euclid runs (up to
// about 46 steps each), and fewer when a point has no solution. i_pt.ready
// is high only while the sequencer is idle; a finished result sits in an
// output register, so the next point is taken while it waits.
// Config writes (i_cfg_we/i_cfg_idx/i_cfg_data) must happen only while idle.
// ----------------------------------------------------------------------------
module congruence_crt_earliest_hit #(
    parameter int MAX_POINTS = crt_pkg::MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [crt_pkg::MOD_W-1:0] i_cfg_data,
    crt_pt_if.sink                    i_pt,
    crt_res_if.source                 o_res
);
    import crt_pkg::*;

    localparam int PC_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // norm_mod for a value given as sign and |v| % m
    function automatic logic [MOD_W-1:0] norm_res(input logic neg,
                                                  input logic [MOD_W-1:0] r,
                                                  input logic [MOD_W-1:0] m);
        norm_res = (neg && (r != '0)) ? MOD_W'(m - r) : r;
    endfunction

    function automatic logic [MOD_W-1:0] mag(input logic signed [SGN_W-1:0] v);
        logic signed [SGN_W-1:0] a;
        a   = v[SGN_W-1] ? -v : v;
        mag = a[MOD_W-1:0];
    endfunction

    // configuration
    logic [MOD_W-1:0] r_mod_x, r_mod_y, r_step_x, r_step_y;
    logic [MOD_W-1:0] nx, ny;

    // sequencer
    t_state r_state, n_state, r_ret;
    logic   r_issued, r_sel;
    logic   op_fire, is_div, pt_fire;

    // run state
    logic [MOD_W-1:0]  r_ref_x, r_ref_y;
    logic [PC_W-1:0]   r_count;
    logic [WIDE_W-1:0] r_best_time;
    logic [PC_W-1:0]   r_best_idx;
    logic              r_have_best;

    // point datapath
    logic [MOD_W-1:0]        r_px, r_py, r_tmp, r_dx, r_dy;
    logic                    r_last;
    logic [MOD_W-1:0]        r_r0, r_r1, r_r2, r_q;
    logic signed [SGN_W-1:0] r_s0, r_s1;
    logic [MOD_W-1:0]        r_bq, r_p, r_nm, r_nd, r_a1, r_a2, r_m1, r_m2, r_m2g;
    logic [MOD_W-1:0]        r_dq, r_k;
    logic                    r_dneg;
    logic [WIDE_W-1:0]       r_cmod;
    logic [WIDE_W-1:0]       n_t;
    logic [MOD_W:0]          n_dd;

    // output register
    logic              r_out_valid, r_found;
    logic [IDX_W-1:0]  r_out_idx;
    logic [WIDE_W-1:0] r_out_time;

    // shared units
    t_div_req                div_req;
    t_div_rsp                div_rsp;
    logic                    mul_en;
    logic signed [SGN_W-1:0] mul_a;
    logic [MOD_W-1:0]        mul_b;
    logic signed [PRD_W-1:0] mul_p;

    crt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    crt_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign nx = (r_mod_x == '0) ? MOD_W'(1) : r_mod_x;
    assign ny = (r_mod_y == '0) ? MOD_W'(1) : r_mod_y;

    assign i_pt.ready = (r_state == ST_IDLE);
    assign pt_fire    = i_pt.valid && i_pt.ready;
    assign op_fire    = r_issued && div_rsp.done;

    // Dividend difference for dq: |a2 - a1|, sign kept in r_dneg.
    assign n_dd = (r_a2 >= r_a1) ? ({1'b0, r_a2} - {1'b0, r_a1})
                                 : ({1'b0, r_a1} - {1'b0, r_a2});
    assign n_t  = r_a1 + mul_p[WIDE_W-1:0];

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (pt_fire) n_state = ST_DX1;
            ST_DX1:    if (op_fire) n_state = ST_DX2;
            ST_DX2:    if (op_fire) n_state = ST_DY1;
            ST_DY1:    if (op_fire) n_state = ST_DY2;
            ST_DY2:    if (op_fire) n_state = ST_EG_DIV;
            ST_EG_DIV: if (op_fire) n_state = ST_EG_MUL;
            ST_EG_MUL: n_state = ST_EG_UPD;
            ST_EG_UPD: n_state = (r_r2 == '0) ? r_ret : ST_EG_DIV;
            ST_SV_CHK: if (op_fire) n_state = (div_rsp.rem != '0) ? ST_FIN : ST_SV_P;
            ST_SV_P:   if (op_fire) n_state = ST_SV_NX;
            ST_SV_NX:  if (op_fire) n_state = ST_SV_MUL;
            ST_SV_MUL: n_state = ST_SV_RED;
            ST_SV_RED: if (op_fire) n_state = ST_EG_DIV;
            ST_CR_A1:  if (op_fire) n_state = ST_CR_A2;
            ST_CR_A2:  if (op_fire) n_state = (div_rsp.rem != r_tmp) ? ST_FIN : ST_CR_M2G;
            ST_CR_M2G: if (op_fire) n_state = ST_CR_CM;
            ST_CR_CM:  n_state = ST_CR_DQ;
            ST_CR_DQ:  if (op_fire) n_state = ST_CR_DQM;
            ST_CR_DQM: if (op_fire) n_state = ST_CR_XM;
            ST_CR_XM:  if (op_fire) n_state = ST_CR_MK;
            ST_CR_MK:  n_state = ST_CR_K;
            ST_CR_K:   if (op_fire) n_state = ST_CR_MT;
            ST_CR_MT:  n_state = ST_CR_T;
            ST_CR_T:   n_state = ST_FIN;
            ST_FIN:    n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (!r_out_valid || o_res.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------- unit controls ----------------
    always_comb begin
        is_div           = 1'b1;
        div_req.wide     = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = MOD_W'(1);
        mul_en           = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        unique case (r_state)
            ST_DX1:    begin div_req.dividend = WIDE_W'(r_px);    div_req.divisor = nx; end
            ST_DX2:    begin div_req.dividend = WIDE_W'(r_ref_x); div_req.divisor = nx; end
            ST_DY1:    begin div_req.dividend = WIDE_W'(r_py);    div_req.divisor = ny; end
            ST_DY2:    begin div_req.dividend = WIDE_W'(r_ref_y); div_req.divisor = ny; end
            ST_EG_DIV: begin div_req.dividend = WIDE_W'(r_r0);    div_req.divisor = r_r1; end
            ST_SV_CHK: begin
                div_req.dividend = WIDE_W'(r_sel ? r_dy : r_dx);
                div_req.divisor  = r_r0;
            end
            ST_SV_P:   begin
                div_req.dividend = WIDE_W'(r_sel ? ny : nx);
                div_req.divisor  = r_r0;
            end
            ST_SV_NX:  begin div_req.dividend = WIDE_W'(mag(r_s0)); div_req.divisor = r_p; end
            ST_SV_RED: begin
                div_req.wide     = 1'b1;
                div_req.dividend = mul_p[WIDE_W-1:0];
                div_req.divisor  = r_p;
            end
            ST_CR_A1:  begin div_req.dividend = WIDE_W'(r_a1); div_req.divisor = r_r0; end
            ST_CR_A2:  begin div_req.dividend = WIDE_W'(r_a2); div_req.divisor = r_r0; end
            ST_CR_M2G: begin div_req.dividend = WIDE_W'(r_m2); div_req.divisor = r_r0; end
            ST_CR_DQ:  begin div_req.dividend = WIDE_W'(n_dd); div_req.divisor = r_r0; end
            ST_CR_DQM: begin div_req.dividend = WIDE_W'(r_dq); div_req.divisor = r_m2g; end
            ST_CR_XM:  begin
                div_req.dividend = WIDE_W'(mag(r_s0));
                div_req.divisor  = r_m2g;
            end
            ST_CR_K:   begin
                div_req.wide     = 1'b1;
                div_req.dividend = mul_p[WIDE_W-1:0];
                div_req.divisor  = r_m2g;
            end
            ST_EG_MUL: begin
                is_div = 1'b0; mul_en = 1'b1; mul_a = r_s1; mul_b = r_q;
            end
            ST_SV_MUL: begin
                is_div = 1'b0; mul_en = 1'b1; mul_a = SGN_W'(r_nm); mul_b = r_bq;
            end
            ST_CR_CM:  begin
                is_div = 1'b0; mul_en = 1'b1; mul_a = SGN_W'(r_m1); mul_b = r_m2g;
            end
            ST_CR_MK:  begin
                is_div = 1'b0; mul_en = 1'b1; mul_a = SGN_W'(r_nm); mul_b = r_nd;
            end
            ST_CR_MT:  begin
                is_div = 1'b0; mul_en = 1'b1; mul_a = SGN_W'(r_m1); mul_b = r_k;
            end
            default:   is_div = 1'b0;
        endcase
        div_req.start = is_div && !r_issued;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_mod_x     <= MOD_W'(1);
            r_mod_y     <= MOD_W'(1);
            r_step_x    <= '0;
            r_step_y    <= '0;
            r_ref_x     <= '0;
            r_ref_y     <= '0;
            r_count     <= '0;
            r_best_time <= '0;
            r_best_idx  <= '0;
            r_have_best <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (div_req.start) r_issued <= 1'b1;
            else if (op_fire)  r_issued <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MOD_X:  r_mod_x  <= i_cfg_data;
                    CFG_MOD_Y:  r_mod_y  <= i_cfg_data;
                    CFG_STEP_X: r_step_x <= i_cfg_data;
                    CFG_STEP_Y: r_step_y <= i_cfg_data;
                    default:    ;
                endcase
            end

            if (pt_fire && !r_have_best) begin
                r_ref_x <= i_pt.pos_x;
                r_ref_y <= i_pt.pos_y;
            end

            // output register: load wins over a draining transfer
            if (r_state == ST_EMIT && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CR_T: begin
                    if (!r_have_best || ((n_t == '0) ? r_cmod : n_t) < r_best_time) begin
                        r_best_time <= (n_t == '0) ? r_cmod : n_t;
                        r_best_idx  <= r_count;
                        r_have_best <= 1'b1;
                    end
                end
                ST_FIN: begin
                    r_count <= (r_count == PC_W'(MAX_POINTS - 1)) ? '0 : r_count + 1'b1;
                end
                ST_EMIT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_ref_x     <= '0;
                        r_ref_y     <= '0;
                        r_count     <= '0;
                        r_best_time <= '0;
                        r_best_idx  <= '0;
                        r_have_best <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (pt_fire) begin
            r_px   <= i_pt.pos_x;
            r_py   <= i_pt.pos_y;
            r_last <= i_pt.last;
        end

        if (r_state == ST_EMIT && (!r_out_valid || o_res.ready)) begin
            r_found    <= r_have_best;
            r_out_idx  <= r_have_best ? IDX_W'(r_best_idx) : '0;
            r_out_time <= r_have_best ? r_best_time : '0;
        end

        if (r_state == ST_EG_UPD) begin
            r_r0 <= r_r1;
            r_r1 <= r_r2;
            r_s0 <= r_s1;
            r_s1 <= r_s0 - mul_p[SGN_W-1:0];
        end

        if (op_fire) begin
            unique case (r_state)
                ST_DX1, ST_DY1, ST_CR_A1: r_tmp <= div_rsp.rem;
                ST_DX2: r_dx <= MOD_W'({1'b0, r_tmp} + (r_tmp >= div_rsp.rem ? '0 : {1'b0, nx})
                                       - {1'b0, div_rsp.rem});
                ST_DY2: begin
                    r_dy  <= MOD_W'({1'b0, r_tmp} + (r_tmp >= div_rsp.rem ? '0 : {1'b0, ny})
                                    - {1'b0, div_rsp.rem});
                    // Euclid on (step_x, mod_x)
                    r_r0  <= r_step_x;
                    r_r1  <= nx;
                    r_s0  <= SGN_W'(1);
                    r_s1  <= '0;
                    r_ret <= ST_SV_CHK;
                    r_sel <= 1'b0;
                end
                ST_EG_DIV: begin
                    r_q  <= div_rsp.quot[MOD_W-1:0];
                    r_r2 <= div_rsp.rem;
                end
                ST_SV_CHK: r_bq <= div_rsp.quot[MOD_W-1:0];
                ST_SV_P:   r_p  <= div_rsp.quot[MOD_W-1:0];
                ST_SV_NX:  r_nm <= norm_res(r_s0[SGN_W-1], div_rsp.rem, r_p);
                ST_SV_RED: begin
                    r_s0 <= SGN_W'(1);
                    r_s1 <= '0;
                    r_r1 <= r_sel ? r_p : ny;
                    if (!r_sel) begin
                        // first congruence done, start Euclid on (step_y, mod_y)
                        r_a1  <= div_rsp.rem;
                        r_m1  <= r_p;
                        r_sel <= 1'b1;
                        r_r0  <= r_step_y;
                        r_ret <= ST_SV_CHK;
                    end else begin
                        // both solved, Euclid on the two periods
                        r_a2  <= div_rsp.rem;
                        r_m2  <= r_p;
                        r_r0  <= r_m1;
                        r_ret <= ST_CR_A1;
                    end
                end
                ST_CR_M2G: r_m2g <= div_rsp.quot[MOD_W-1:0];
                ST_CR_DQ: begin
                    r_cmod <= mul_p[WIDE_W-1:0];
                    r_dq   <= div_rsp.quot[MOD_W-1:0];
                    r_dneg <= (r_a2 < r_a1);
                end
                ST_CR_DQM: r_nd <= norm_res(r_dneg, div_rsp.rem, r_m2g);
                ST_CR_XM:  r_nm <= norm_res(r_s0[SGN_W-1], div_rsp.rem, r_m2g);
                ST_CR_K:   r_k  <= div_rsp.rem;
                default: ;
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.found      = r_found;
    assign o_res.best_index = r_out_idx;
    assign o_res.best_time  = r_out_time;
endmodule

// ===== test/crt_tb_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crt_tb_if: testbench-side package
// The channel interfaces come from the RTL; this file only holds the timescale
// for the testbench's interface use and the directed-table row record.
// ----------------------------------------------------------------------------
package crt_tb_pkg;
    import crt_pkg::*;

    typedef struct {
        logic [MOD_W-1:0] pos_x;
        logic [MOD_W-1:0] pos_y;
        logic             last;
        logic             chk;   // 1: typed-in result below is also checked
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [61:0]      tm;
    } t_pt_row;
endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: earliest-hit CRT block
// Directed table, then random runs of points under random config, checked
// transfer by transfer against a behavioral predictor of the congruence math.
// ----------------------------------------------------------------------------
module testbench;
    import crt_pkg::*;
    import crt_tb_pkg::*;

    typedef struct {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [61:0]      tm;
    } t_hit;

    localparam int WATCHDOG = 400000;   // limit on idle cycles without a transfer
    localparam int STALL_CYCLES = 20000; // long receiver stall

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = CFG_MOD_X;
    logic [MOD_W-1:0] i_cfg_data = '0;

    crt_pt_if  pt_ch ();
    crt_res_if res_ch ();

    congruence_crt_earliest_hit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pt(pt_ch.sink), .o_res(res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: config copy and run state
    longint unsigned p_modx = 1, p_mody = 1, p_stx = 0, p_sty = 0;
    longint unsigned p_refx, p_refy, p_cnt, p_btime, p_bidx;
    bit p_have;

    t_hit hit_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 0;         // long receiver stall request

    // extended Euclid: returns gcd, s = Bezout coefficient of a
    function automatic longint unsigned egcd(longint unsigned a, longint unsigned b,
                                             output longint s);
        longint unsigned r0, r1, q, r2;
        longint s0, s1, s2;
        r0 = a; r1 = b; s0 = 1; s1 = 0;
        while (r1 != 0) begin
            q = r0 / r1;
            r2 = r0 - q * r1;
            s2 = s0 - longint'(q) * s1;
            r0 = r1; r1 = r2; s0 = s1; s1 = s2;
        end
        s = s0;
        return r0;
    endfunction

    function automatic longint unsigned nmod(longint v, longint unsigned m);
        longint r;
        r = v % longint'(m);
        if (r < 0) r += longint'(m);
        return longint'(r);
    endfunction

    function automatic bit solve_cong(longint unsigned a, longint unsigned b,
                                      longint unsigned m, output longint unsigned res,
                                      output longint unsigned per);
        longint s;
        longint unsigned g;
        g = egcd(a, m, s);
        res = 0; per = 1;
        if (b % g != 0) return 0;
        per = m / g;
        res = (nmod(s, per) * ((b / g) % per)) % per;
        return 1;
    endfunction

    function automatic void cfg_shadow(logic [1:0] idx, longint unsigned v);
        case (idx)
            CFG_MOD_X:  p_modx = v;
            CFG_MOD_Y:  p_mody = v;
            CFG_STEP_X: p_stx = v;
            default:    p_sty = v;
        endcase
    endfunction

    function automatic void clear_run();
        p_refx = 0; p_refy = 0; p_cnt = 0; p_btime = 0; p_bidx = 0; p_have = 0;
    endfunction

    // advance the predictor by one point; queue a hit on the last one
    function automatic void predict_point(longint unsigned px, longint unsigned py,
                                          bit last);
        longint unsigned nx, ny, dx, dy, a1, m1, a2, m2, g, m2g, cm, k, t;
        longint s, dq;
        t_hit h;
        nx = p_modx ? p_modx : 1;
        ny = p_mody ? p_mody : 1;
        if (!p_have) begin
            p_refx = px; p_refy = py;
        end
        dx = (px % nx + nx - p_refx % nx) % nx;
        dy = (py % ny + ny - p_refy % ny) % ny;
        if (solve_cong(p_stx, dx, nx, a1, m1) && solve_cong(p_sty, dy, ny, a2, m2)) begin
            g = egcd(m1, m2, s);
            if (a1 % g == a2 % g) begin
                m2g = m2 / g;
                cm = m1 * m2g;
                dq = (longint'(a2) - longint'(a1)) / longint'(g);
                k = (nmod(s, m2g) * nmod(dq, m2g)) % m2g;
                t = a1 + m1 * k;
                if (t == 0) t = cm;
                if (!p_have || t < p_btime) begin
                    p_btime = t & 62'h3FFF_FFFF_FFFF_FFFF;
                    p_bidx = p_cnt & 16'hFFFF;
                    p_have = 1;
                end
            end
        end
        p_cnt = (p_cnt + 1) % MAX_POINTS_DEF;
        if (last) begin
            h.found = p_have;
            h.idx = p_have ? p_bidx[15:0] : '0;
            h.tm = p_have ? p_btime[61:0] : '0;
            hit_q.push_back(h);
            clear_run();
        end
    endfunction

    // ---- result side: random ready, one long stall on request ----
    initial begin
        int gap;
        bit stalled;
        stalled = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off && !stalled) begin
                // long stall counted here while the sender keeps offering points
                stalled = 1;
                res_ch.ready = 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            res_ch.ready = 1'b0;
            repeat (gap) @(negedge i_clk);
            res_ch.ready = 1'b1;
            // keep ready high until a transfer happens
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // sampling at the rising edge; ready/valid both high = transfer
    always @(posedge i_clk) begin
        t_hit e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (hit_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result found=%0b idx=%0d time=%0d", $time,
                         res_ch.found, res_ch.best_index, res_ch.best_time);
            end else begin
                e = hit_q.pop_front();
                if (res_ch.found !== e.found) begin
                    errors++;
                    $display("%0t: found exp %0b got %0b", $time, e.found, res_ch.found);
                end
                if (res_ch.best_index !== e.idx) begin
                    errors++;
                    $display("%0t: best_index exp %0d got %0d", $time, e.idx,
                             res_ch.best_index);
                end
                if (res_ch.best_time !== e.tm) begin
                    errors++;
                    $display("%0t: best_time exp %0d got %0d", $time, e.tm,
                             res_ch.best_time);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one point transfer; row check compares the typed-in value with the predictor
    task automatic send_point(t_pt_row r, int gap);
        repeat (gap) @(negedge i_clk);
        pt_ch.pos_x = r.pos_x;
        pt_ch.pos_y = r.pos_y;
        pt_ch.last = r.last;
        pt_ch.valid = 1'b1;
        do @(posedge i_clk); while (!pt_ch.ready);
        predict_point(r.pos_x, r.pos_y, r.last);
        if (r.chk) begin
            if (hit_q[$].found !== r.found || hit_q[$].idx !== r.idx ||
                hit_q[$].tm !== r.tm) begin
                errors++;
                $display("%0t: table row exp %0b/%0d/%0d predictor %0b/%0d/%0d", $time,
                         r.found, r.idx, r.tm, hit_q[$].found, hit_q[$].idx,
                         hit_q[$].tm);
            end
        end
        @(negedge i_clk);
        pt_ch.valid = 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [MOD_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_shadow(idx, v);
    endtask

    // drain: all results in, then extra cycles for a point with no result
    task automatic drain();
        while (hit_q.size() != 0) @(negedge i_clk);
        repeat (6000) @(negedge i_clk);
    endtask

    task automatic set_cfg(logic [MOD_W-1:0] mx, logic [MOD_W-1:0] my,
                           logic [MOD_W-1:0] sx, logic [MOD_W-1:0] sy);
        drain();
        write_reg(CFG_MOD_X, mx);
        write_reg(CFG_MOD_Y, my);
        write_reg(CFG_STEP_X, sx);
        write_reg(CFG_STEP_Y, sy);
    endtask

    function automatic logic [MOD_W-1:0] rnd_mod(int sel);
        case (sel)
            0: return MOD_W'($urandom_range(1, 16));
            1: return MOD_W'($urandom_range(1, 1000));
            2: return MOD_W'(32'h7FFF_FFFF - $urandom_range(0, 3));
            3: return '0;
            default: return MOD_W'($urandom());
        endcase
    endfunction

    initial begin
        t_pt_row tbl[$];
        t_pt_row r;
        int n, len, pick;
        logic [MOD_W-1:0] mx, my;
        pt_ch.valid = 1'b0;
        pt_ch.pos_x = '0;
        pt_ch.pos_y = '0;
        pt_ch.last = 1'b0;
        clear_run();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // after reset: moduli 1, so every point solves with time 1 (zero -> cmod)
        tbl.push_back('{31'h7FFF_FFFF, 31'h0, 1, 1, 1, 0, 1});
        tbl.push_back('{31'h0, 31'h7FFF_FFFF, 1, 1, 1, 0, 1});
        foreach (tbl[i]) send_point(tbl[i], $urandom_range(0, 12));
        tbl.delete();

        // small moduli, steps 1: time equals offset, zero offset -> period
        set_cfg(7, 5, 1, 1);
        tbl.push_back('{10, 20, 0, 0, 0, 0, 0});   // reference
        tbl.push_back('{13, 23, 0, 0, 0, 0, 0});   // t=3
        tbl.push_back('{11, 21, 1, 1, 1, 2, 1});   // t=1 wins at index 2
        // new run with the reference at the origin
        tbl.push_back('{0, 0, 0, 0, 0, 0, 0});     // t=35
        tbl.push_back('{1, 0, 0, 0, 0, 0, 0});     // t=1 mod 7, t=0 mod 5 -> 15
        tbl.push_back('{0, 0, 1, 1, 1, 1, 15});    // t=35, index 1 keeps t=15
        foreach (tbl[i]) send_point(tbl[i], $urandom_range(0, 12));
        tbl.delete();
        // steps 0: periods collapse to 1, nonzero offset has no solution
        set_cfg(6, 4, 0, 0);
        tbl.push_back('{3, 3, 0, 0, 0, 0, 0});     // reference, t = 1
        tbl.push_back('{4, 3, 1, 1, 1, 0, 1});     // no solution, reference kept
        foreach (tbl[i]) send_point(tbl[i], $urandom_range(0, 12));
        tbl.delete();
        // extreme moduli and steps, zero modulus acts as 1
        set_cfg(31'h7FFF_FFFF, '0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        tbl.push_back('{31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0, 0, 0});
        tbl.push_back('{0, 0, 0, 0, 0, 0, 0});
        tbl.push_back('{31'h1234_5678, 31'h4321_0000, 1, 0, 0, 0, 0});
        foreach (tbl[i]) send_point(tbl[i], $urandom_range(0, 12));
        tbl.delete();

        // random phases
        n = 0;
        while (n < 2000) begin
            pick = $urandom_range(0, 5);
            mx = rnd_mod(pick);
            my = rnd_mod($urandom_range(0, 5));
            set_cfg(mx, my, ($urandom_range(0, 3) == 0) ? '0 : MOD_W'($urandom()),
                    ($urandom_range(0, 7) == 0) ? 31'h7FFF_FFFF :
                    (pick < 2 ? MOD_W'($urandom_range(0, 20)) : MOD_W'($urandom())));
            repeat ($urandom_range(3, 10)) begin
                len = $urandom_range(1, 10);
                for (int j = 0; j < len; j++) begin
                    r.pos_x = MOD_W'($urandom());
                    r.pos_y = MOD_W'($urandom());
                    if (pick < 2 && $urandom_range(0, 1)) begin
                        r.pos_x = MOD_W'($urandom_range(0, 40));
                        r.pos_y = MOD_W'($urandom_range(0, 40));
                    end
                    r.last = (j == len - 1);
                    r.chk = 0; r.found = 0; r.idx = 0; r.tm = 0;
                    send_point(r, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 12));
                    n++;
                end
            end
            if (n > 600 && !hold_off) begin
                // long receiver stall while single-point runs keep coming
                hold_off = 1;
                for (int j = 0; j < 6; j++) begin
                    r.pos_x = MOD_W'($urandom());
                    r.pos_y = MOD_W'($urandom());
                    r.last = 1; r.chk = 0; r.found = 0; r.idx = 0; r.tm = 0;
                    send_point(r, $urandom_range(0, 12));
                    n++;
                end
            end
        end

        drain();
        if (errors == 0 && hit_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/crt_pkg.sv
rtl/core/crt_pt_if.sv
rtl/core/crt_res_if.sv
rtl/core/crt_div.sv
rtl/core/crt_mul.sv
rtl/core/congruence_crt_earliest_hit.sv
test/crt_tb_if.sv
test/testbench.sv
